@@ rtl/rtpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtpd_pkg;

    // Largest frame length the design supports, from the two-byte prefix.
    localparam int FRAME_LIMIT_DEF = 8192;

    // Smallest body that can hold a fixed RTP header.
    localparam logic [13:0] RTP_HDR_LEN = 14'd12;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FILTER_EN  = 2'd0;
    localparam logic [1:0] CFG_FILTER_VAL = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

    // Reset value of the length limit register.
    localparam logic [13:0] MAX_LEN_RST = 14'd8192;

    // Input item kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    // Byte roles on the result stream.
    localparam logic [1:0] ROLE_PREFIX  = 2'd0;
    localparam logic [1:0] ROLE_BODY    = 2'd1;
    localparam logic [1:0] ROLE_DISCARD = 2'd2;
    localparam logic [1:0] ROLE_RESET   = 2'd3;

    // Frame verdicts.
    localparam logic [2:0] VERD_NONE    = 3'd0;
    localparam logic [2:0] VERD_RTP     = 3'd1;
    localparam logic [2:0] VERD_DROPPED = 3'd2;
    localparam logic [2:0] VERD_RAW     = 3'd3;
    localparam logic [2:0] VERD_BAD_LEN = 3'd4;

    // Framing phase.
    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CLOSED
    } t_phase;

    // Configuration register set.
    typedef struct packed {
        logic        filter_en;
        logic [6:0]  filter_val;
        logic [13:0] max_len;
    } t_cfg;

    // Verdict fields of a completed frame.
    typedef struct packed {
        logic [2:0]  verdict;
        logic [12:0] payload_offset;
        logic [13:0] payload_length;
        logic [31:0] rtp_timestamp;
        logic [6:0]  rtp_pt;
    } t_verdict;

    // One result item.
    typedef struct packed {
        logic [7:0]  echo_byte;
        logic [1:0]  byte_role;
        logic [12:0] frame_position;
        logic        frame_end;
        t_verdict    vd;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rtpd_judge.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Checks a completed frame body for a well-formed RTP header and derives
// the payload window.
module rtpd_judge
    import rtpd_pkg::*;
(
    input  wire logic [13:0] i_size,
    input  wire logic [7:0]  i_hdr0,
    input  wire logic [6:0]  i_type,
    input  wire logic [31:0] i_ts,
    input  wire logic [15:0] i_ext,
    input  wire logic [7:0]  i_last_byte,
    input  wire logic        i_filter_en,
    input  wire logic [6:0]  i_filter_val,
    output t_verdict         o_vd
);

    logic [18:0] off_fix;
    logic [18:0] off_ext_hdr;
    logic [18:0] off_ext;
    logic [18:0] off_sel;
    logic [18:0] size_w;
    logic [13:0] pay;
    logic [13:0] pay_pad;
    logic        ok_fix;
    logic        ok_ext;
    logic        ok_pad;
    logic        ok;

    // Fixed header plus CSRC list, then the optional extension.
    always_comb begin
        size_w      = {5'd0, i_size};
        off_fix     = 19'd12 + {13'd0, i_hdr0[3:0], 2'b00};
        off_ext_hdr = off_fix + 19'd4;
        off_ext     = off_ext_hdr + {1'b0, i_ext, 2'b00};
        ok_fix      = (i_size >= RTP_HDR_LEN) && (i_hdr0[7:6] == 2'd2) && (off_fix <= size_w);
        ok_ext      = !i_hdr0[4] || ((off_ext_hdr <= size_w) && (off_ext <= size_w));
        off_sel     = i_hdr0[4] ? off_ext : off_fix;
    end

    // Payload size, less the padding when the padding bit is set.
    always_comb begin
        pay     = i_size - off_sel[13:0];
        ok_pad  = !i_hdr0[5] || ((i_last_byte != 8'd0) && ({6'd0, i_last_byte} <= pay));
        pay_pad = i_hdr0[5] ? (pay - {6'd0, i_last_byte}) : pay;
        ok      = ok_fix && ok_ext && ok_pad && (pay_pad != 14'd0);
    end

    // Verdict fields; a body that fails a check is passed on raw.
    always_comb begin
        if (ok) begin
            o_vd.verdict        = (i_filter_en && (i_type != i_filter_val)) ?
                                  VERD_DROPPED : VERD_RTP;
            o_vd.payload_offset = off_sel[12:0];
            o_vd.payload_length = pay_pad;
            o_vd.rtp_timestamp  = i_ts;
            o_vd.rtp_pt         = i_type;
        end else begin
            o_vd.verdict        = VERD_RAW;
            o_vd.payload_offset = 13'd0;
            o_vd.payload_length = i_size;
            o_vd.rtp_timestamp  = 32'd0;
            o_vd.rtp_pt         = 7'd0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rtpd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Framing state machine and header capture. The result for the item in the
// input register is formed combinationally; state advances on i_step.
module rtpd_parser
    import rtpd_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output t_result         o_res
);

    localparam logic [15:0] LimitW = 16'(FRAME_LIMIT);

    t_phase      r_phase, n_phase;
    logic [13:0] r_frame_len, n_frame_len;
    logic [13:0] r_body_pos, n_body_pos;
    logic [7:0]  r_hdr0, n_hdr0;
    logic [6:0]  r_type, n_type;
    logic [31:0] r_ts, n_ts;
    logic [15:0] r_ext, n_ext;

    logic [15:0] len_word;
    logic [15:0] limit;
    logic        len_bad;
    logic [6:0]  ext_at;
    logic [14:0] pos_inc;
    logic        body_last;
    t_verdict    judge_vd;

    // Length prefix check against the smaller of register and design limit.
    always_comb begin
        len_word  = {r_frame_len[7:0], i_byte};
        limit     = ({2'b00, i_cfg.max_len} > LimitW) ? LimitW : {2'b00, i_cfg.max_len};
        len_bad   = (len_word == 16'd0) || (len_word > limit);
        ext_at    = 7'd14 + {3'd0, r_hdr0[3:0]} * 7'd4;
        pos_inc   = {1'b0, r_body_pos} + 15'd1;
        body_last = pos_inc >= {1'b0, r_frame_len};
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_kind == KIND_RESET) begin
            n_phase = PH_LEN_HI;
        end else begin
            case (r_phase)
                PH_LEN_HI: n_phase = PH_LEN_LO;
                PH_LEN_LO: n_phase = len_bad ? PH_CLOSED : PH_BODY;
                PH_BODY:   n_phase = body_last ? PH_LEN_HI : PH_BODY;
                PH_CLOSED: n_phase = PH_CLOSED;
                default:   n_phase = PH_LEN_HI;
            endcase
        end
    end

    // Next values of the length, position and captured header fields.
    always_comb begin
        n_frame_len = r_frame_len;
        n_body_pos  = r_body_pos;
        n_hdr0      = r_hdr0;
        n_type      = r_type;
        n_ts        = r_ts;
        n_ext       = r_ext;
        if (i_kind == KIND_RESET) begin
            n_frame_len = 14'd0;
            n_body_pos  = 14'd0;
            n_hdr0      = 8'd0;
            n_type      = 7'd0;
            n_ts        = 32'd0;
            n_ext       = 16'd0;
        end else begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_frame_len = {6'd0, i_byte};
                end
                PH_LEN_LO: begin
                    if (len_bad) begin
                        n_frame_len = 14'd0;
                    end else begin
                        n_frame_len = len_word[13:0];
                        n_body_pos  = 14'd0;
                        n_hdr0      = 8'd0;
                        n_type      = 7'd0;
                        n_ts        = 32'd0;
                        n_ext       = 16'd0;
                    end
                end
                PH_BODY: begin
                    if (r_body_pos == 14'd0) begin
                        n_hdr0 = i_byte;
                    end else if (r_body_pos == 14'd1) begin
                        n_type = i_byte[6:0];
                    end else if ((r_body_pos >= 14'd4) && (r_body_pos <= 14'd7)) begin
                        n_ts = {r_ts[23:0], i_byte};
                    end
                    if (r_body_pos == {7'd0, ext_at}) begin
                        n_ext = {i_byte, 8'd0};
                    end else if (r_body_pos == ({7'd0, ext_at} + 14'd1)) begin
                        n_ext = {r_ext[15:8], i_byte};
                    end
                    if (body_last) begin
                        n_frame_len = 14'd0;
                        n_body_pos  = 14'd0;
                    end else begin
                        n_body_pos = pos_inc[13:0];
                    end
                end
                PH_CLOSED: begin
                    n_frame_len = r_frame_len;
                end
                default: begin
                    n_frame_len = r_frame_len;
                end
            endcase
        end
    end

    // Verdict of the frame that ends with this byte.
    rtpd_judge u_judge (
        .i_size       (r_frame_len),
        .i_hdr0       (n_hdr0),
        .i_type       (n_type),
        .i_ts         (n_ts),
        .i_ext        (n_ext),
        .i_last_byte  (i_byte),
        .i_filter_en  (i_cfg.filter_en),
        .i_filter_val (i_cfg.filter_val),
        .o_vd         (judge_vd)
    );

    // Result item.
    always_comb begin
        o_res                    = '0;
        o_res.vd.verdict         = VERD_NONE;
        if (i_kind == KIND_RESET) begin
            o_res.byte_role = ROLE_RESET;
        end else begin
            o_res.echo_byte = i_byte;
            case (r_phase)
                PH_LEN_HI: begin
                    o_res.byte_role = ROLE_PREFIX;
                end
                PH_LEN_LO: begin
                    o_res.byte_role = ROLE_PREFIX;
                    if (len_bad) begin
                        o_res.frame_end  = 1'b1;
                        o_res.vd.verdict = VERD_BAD_LEN;
                    end
                end
                PH_BODY: begin
                    o_res.byte_role      = ROLE_BODY;
                    o_res.frame_position = r_body_pos[12:0];
                    if (body_last) begin
                        o_res.frame_end = 1'b1;
                        o_res.vd        = judge_vd;
                    end
                end
                PH_CLOSED: begin
                    o_res.byte_role = ROLE_DISCARD;
                end
                default: begin
                    o_res.byte_role = ROLE_DISCARD;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN_HI;
            r_frame_len <= 14'd0;
            r_body_pos  <= 14'd0;
            r_hdr0      <= 8'd0;
            r_type      <= 7'd0;
            r_ts        <= 32'd0;
            r_ext       <= 16'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_body_pos  <= n_body_pos;
            r_hdr0      <= n_hdr0;
            r_type      <= n_type;
            r_ts        <= n_ts;
            r_ext       <= n_ext;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rtp_over_tcp_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width          Content
// s_axis    in         8 + 1 user     stream byte, item kind in tuser
// m_axis    out        96 + 2 + last  echoed byte and frame verdict
// cfg       in         2 + 14         register index and write data
//
// One item is accepted per clock cycle while s_axis_tready is high; its result
// passes from the input register to the result register when the latter is free.
// Reset clears the framing state, valid flags and filter, and sets max_len to 8192.
// While m_axis_tready is low a valid result holds, and the input register still
// takes one more item, if it is empty, before s_axis_tready drops.
module rtp_over_tcp_deframer
    import rtpd_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  wire logic        s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] echo_byte, [20:8] frame_position, [23:21] verdict,
    // [36:24] payload_offset, [50:37] payload_length, [82:51] rtp_timestamp,
    // [89:83] rtp_pt, [95:90] zero
    output logic [95:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] byte_role
    output logic             m_axis_tlast,   // frame_end
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    logic       out_free;
    logic       step;
    t_result    res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_en  <= 1'b0;
            r_cfg.filter_val <= 7'd0;
            r_cfg.max_len    <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILTER_EN:  r_cfg.filter_en  <= i_cfg_data[0];
                CFG_FILTER_VAL: r_cfg.filter_val <= i_cfg_data[6:0];
                CFG_MAX_LEN:    r_cfg.max_len    <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Handshake: the input register moves on when the result register is free.
    assign out_free      = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    rtpd_parser #(
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.byte_role;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tdata  = {6'd0,
                            r_out.vd.rtp_pt,
                            r_out.vd.rtp_timestamp,
                            r_out.vd.payload_length,
                            r_out.vd.payload_offset,
                            r_out.vd.verdict,
                            r_out.frame_position,
                            r_out.echo_byte};

endmodule

`default_nettype wire
